// ----- hw/rtl/pms_pkg.sv -----
// Shared types and constants for the per-pixel median stacking core.
package pms_pkg;

    localparam int CHANNELS = 3;
    localparam int FIELD_W  = 8;
    localparam int CFG_W    = 5;

    localparam logic [CFG_W-1:0] IMAGE_COUNT_RESET = 5'd9;

    // Per-cell control, common to all channels of a cell
    typedef struct packed {
        logic load;      // a word is accepted this cycle
        logic occupied;  // cell index is below the current fill count
    } cell_ctrl_t;

endpackage

// ----- hw/rtl/pms_cell.sv -----
// One cell of the sorted insertion chain: holds one sample per channel.
module pms_cell
    import pms_pkg::*;
#(
    parameter int SAMPLE_BITS = 8
)
(
    input  logic                                  clk,
    input  cell_ctrl_t                            ctrl,
    input  logic [CHANNELS-1:0][SAMPLE_BITS-1:0]  sample,
    input  logic [CHANNELS-1:0][SAMPLE_BITS-1:0]  left_value,
    input  logic [CHANNELS-1:0]                   left_gt,
    output logic [CHANNELS-1:0][SAMPLE_BITS-1:0]  value,
    output logic [CHANNELS-1:0][SAMPLE_BITS-1:0]  value_next,
    output logic [CHANNELS-1:0]                   gt
);

    logic [CHANNELS-1:0][SAMPLE_BITS-1:0] value_reg;
    logic [CHANNELS-1:0]                  keep;

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            gt[c]   = ctrl.occupied && (value_reg[c] > sample[c]);
            keep[c] = ctrl.occupied && !(value_reg[c] > sample[c]);
            // keep own value, shift in from the left neighbor, or take the new sample
            if (keep[c])
            begin
                value_next[c] = value_reg[c];
            end
            else if (left_gt[c])
            begin
                value_next[c] = left_value[c];
            end
            else
            begin
                value_next[c] = sample[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

// ----- hw/rtl/pms_median_out.sv -----
// Median pick from the chain's next values and the output word register.
module pms_median_out
    import pms_pkg::*;
#(
    parameter int MAX_IMAGES  = 16,
    parameter int SAMPLE_BITS = 8,
    parameter int IDX_W       = 4
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  capture,
    input  logic [IDX_W-1:0]                      mid_index,
    input  logic [CHANNELS-1:0][SAMPLE_BITS-1:0]  chain_next [MAX_IMAGES],
    input  logic                                  out_stall,
    output logic                                  out_valid,
    output logic [FIELD_W-1:0]                    median_red,
    output logic [FIELD_W-1:0]                    median_green,
    output logic [FIELD_W-1:0]                    median_blue
);

    logic                                  valid_reg;
    logic                                  valid_next;
    logic [CHANNELS-1:0][FIELD_W-1:0]      median_reg;
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0]  picked;

    assign picked = chain_next[mid_index];

    always_comb
    begin
        valid_next = valid_reg;
        if (capture)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                median_reg[c] <= FIELD_W'(picked[c]);
            end
        end
    end

    assign out_valid    = valid_reg;
    assign median_red   = median_reg[0];
    assign median_green = median_reg[1];
    assign median_blue  = median_reg[2];

endmodule

// ----- hw/rtl/per_pixel_median_stack_core.sv -----
// Per-pixel median stacking core: sorted cell chain, fill count and output stage.
//
// Input channel (in_valid / in_stall, red / green / blue) carries one pixel's
// samples from successive aligned images, one image per word. Each word is
// inserted into a sorted chain of MAX_IMAGES cells (one cell row per sample slot,
// three channels per cell); one word is taken per clock while in_stall is low.
// When image_count words have been gathered, the median of each channel (sorted
// index count/2, upper middle for even counts) is registered and offered on the
// output channel (out_valid / out_stall, median_red / green / blue) in the cycle after
// the completing word is accepted; the chain then starts the next pixel.
// The output register parts the two sides: words that do not complete a pixel
// keep flowing while a result waits. Only a completing word is stalled while the
// previous result is still held by the receiver.
// Configuration: cfg_valid / cfg_ready / cfg_data writes image_count (zero acts as
// one, values above MAX_IMAGES act as MAX_IMAGES); write only while idle.
// Reset: image_count returns to 9, the fill count to zero, no result is pending.
// The cell contents are not cleared; the fill count marks which cells hold data.
module per_pixel_median_stack_core
    import pms_pkg::*;
#(
    parameter int MAX_IMAGES  = 16,
    parameter int SAMPLE_BITS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [FIELD_W-1:0]  red,
    input  logic [FIELD_W-1:0]  green,
    input  logic [FIELD_W-1:0]  blue,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [FIELD_W-1:0]  median_red,
    output logic [FIELD_W-1:0]  median_green,
    output logic [FIELD_W-1:0]  median_blue,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_W-1:0]    cfg_data
);

    localparam int COUNT_W = $clog2(MAX_IMAGES + 1);
    localparam int IDX_W   = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1;
    localparam int CMP_W   = (COUNT_W > CFG_W) ? COUNT_W : CFG_W;

    logic [CFG_W-1:0]   image_count_reg;
    logic [COUNT_W-1:0] seen_reg;
    logic [COUNT_W-1:0] seen_next;
    logic [COUNT_W-1:0] seen_plus;
    logic [CMP_W-1:0]   count_ext;
    logic [CMP_W-1:0]   count_sat;
    logic [COUNT_W-1:0] count_eff;
    logic [COUNT_W-1:0] mid;
    logic               complete;
    logic               accept;
    logic               capture;

    logic [CHANNELS-1:0][SAMPLE_BITS-1:0] sample;
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0] cell_value [MAX_IMAGES];
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0] cell_next  [MAX_IMAGES];
    logic [CHANNELS-1:0]                  cell_gt    [MAX_IMAGES];

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_count_reg <= IMAGE_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            image_count_reg <= cfg_data;
        end
    end

    always_comb
    begin
        count_ext = CMP_W'(image_count_reg);
        if (count_ext == '0)
        begin
            count_sat = CMP_W'(1);
        end
        else if (count_ext > CMP_W'(MAX_IMAGES))
        begin
            count_sat = CMP_W'(MAX_IMAGES);
        end
        else
        begin
            count_sat = count_ext;
        end
    end

    assign count_eff = COUNT_W'(count_sat);

    // fill count and handshake
    assign seen_plus = seen_reg + COUNT_W'(1);
    assign complete  = (seen_plus >= count_eff);
    assign mid       = seen_plus >> 1;
    assign in_stall  = out_valid && out_stall && complete;
    assign accept    = in_valid && !in_stall;
    assign capture   = accept && complete;

    always_comb
    begin
        seen_next = seen_reg;
        if (accept)
        begin
            seen_next = complete ? '0 : seen_plus;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else
        begin
            seen_reg <= seen_next;
        end
    end

    assign sample[0] = SAMPLE_BITS'(red);
    assign sample[1] = SAMPLE_BITS'(green);
    assign sample[2] = SAMPLE_BITS'(blue);

    // sorted insertion chain
    for (genvar i = 0; i < MAX_IMAGES; i++)
    begin : g_cell
        cell_ctrl_t                           ctrl;
        logic [CHANNELS-1:0][SAMPLE_BITS-1:0] left_value;
        logic [CHANNELS-1:0]                  left_gt;

        assign ctrl.load     = accept;
        assign ctrl.occupied = (COUNT_W'(i) < seen_reg);

        if (i == 0)
        begin : g_head
            assign left_value = sample;
            assign left_gt    = '0;
        end
        else
        begin : g_body
            assign left_value = cell_value[i-1];
            assign left_gt    = cell_gt[i-1];
        end

        pms_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .sample     (sample),
            .left_value (left_value),
            .left_gt    (left_gt),
            .value      (cell_value[i]),
            .value_next (cell_next[i]),
            .gt         (cell_gt[i])
        );
    end

    pms_median_out #(
        .MAX_IMAGES  (MAX_IMAGES),
        .SAMPLE_BITS (SAMPLE_BITS),
        .IDX_W       (IDX_W)
    ) u_median_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .capture      (capture),
        .mid_index    (mid[IDX_W-1:0]),
        .chain_next   (cell_next),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .median_red   (median_red),
        .median_green (median_green),
        .median_blue  (median_blue)
    );

    // checks
    a_seen_below_max: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg < COUNT_W'(MAX_IMAGES))
        else $error("fill count reached chain depth");

    a_seen_advance: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !complete |=> seen_reg == $past(seen_plus))
        else $error("fill count did not advance on a non-final word");

    a_seen_clear: assert property (@(posedge clk) disable iff (!rst_n)
        capture |=> seen_reg == '0)
        else $error("fill count not cleared after a pixel");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        capture |=> out_valid)
        else $error("completed pixel gave no result word");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall && complete |-> !capture)
        else $error("held result overwritten");

endmodule

// ----- bench/per_pixel_median_stack_core_tb.sv -----
// Self-checking bench for the per-pixel median stacking core.
`timescale 1ns / 100ps

module per_pixel_median_stack_core_tb;
    import pms_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int MAX_IMAGES    = 16;
    localparam int RANDOM_WORDS  = 1800;
    localparam int SETTLE_CYCLES = 3;
    localparam int DRAIN_CYCLES  = 10;

    typedef logic [CHANNELS-1:0][FIELD_W-1:0] pixel_t;   // [0] red, [1] green, [2] blue

    typedef enum logic {ROW_CONFIG, ROW_WORD} row_kind_e;

    typedef struct packed {
        row_kind_e         kind;
        logic [CFG_W-1:0]  count;
        pixel_t            word;
        logic              typed;
        pixel_t            want;
    } stim_row_t;

    typedef enum logic [1:0] {STALL_NONE, STALL_SPARSE, STALL_PERIODIC, STALL_HEAVY} stall_mode_e;
    typedef enum logic [1:0] {DATA_FULL, DATA_NARROW, DATA_EXTREME, DATA_EDGE} data_mode_e;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [FIELD_W-1:0] red = '0;
    logic [FIELD_W-1:0] green = '0;
    logic [FIELD_W-1:0] blue = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [FIELD_W-1:0] median_red;
    logic [FIELD_W-1:0] median_green;
    logic [FIELD_W-1:0] median_blue;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data = '0;

    // predictor state
    logic [FIELD_W-1:0] sorted_samples [CHANNELS][MAX_IMAGES];
    int                 fill_count = 0;
    logic [CFG_W-1:0]   image_count_cfg = IMAGE_COUNT_RESET;

    pixel_t             median_q [$];
    int                 mismatches = 0;
    int                 words_sent = 0;
    int                 medians_checked = 0;
    int                 cfg_writes = 0;

    stall_mode_e        stall_mode = STALL_NONE;
    int                 mode_timer = 0;
    logic [3:0]         stall_phase = '0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    per_pixel_median_stack_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .median_red   (median_red),
        .median_green (median_green),
        .median_blue  (median_blue),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    function automatic pixel_t px(input int r, input int g, input int b);
        pixel_t p;
        p[0] = r[FIELD_W-1:0];
        p[1] = g[FIELD_W-1:0];
        p[2] = b[FIELD_W-1:0];
        return p;
    endfunction

    task automatic log_failure(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%t: %s", $realtime, msg);
    endtask

    // Insert one word into the sorted stores; report the median when the pixel completes.
    task automatic stack_sample(input pixel_t s, output bit done, output pixel_t med);
        int target;
        int pos;
        int mid;
        if (image_count_cfg == 0)
            target = 1;
        else if (image_count_cfg > MAX_IMAGES)
            target = MAX_IMAGES;
        else
            target = image_count_cfg;
        for (int c = 0; c < CHANNELS; c++)
        begin
            pos = fill_count;
            while (pos > 0 && sorted_samples[c][pos-1] > s[c])
            begin
                sorted_samples[c][pos] = sorted_samples[c][pos-1];
                pos--;
            end
            sorted_samples[c][pos] = s[c];
        end
        fill_count++;
        done = (fill_count >= target);
        med = '0;
        if (done)
        begin
            // upper middle for even counts; a lowered count takes all gathered samples
            mid = fill_count / 2;
            for (int c = 0; c < CHANNELS; c++)
                med[c] = sorted_samples[c][mid];
            fill_count = 0;
        end
    endtask

    task automatic send_word(input pixel_t w, input logic typed, input pixel_t want);
        bit done;
        pixel_t med;
        in_valid <= 1'b1;
        red      <= w[0];
        green    <= w[1];
        blue     <= w[2];
        do @(posedge clk); while (in_stall);
        stack_sample(w, done, med);
        if (done)
            median_q.insert(median_q.size(), typed ? want : med);
        words_sent++;
    endtask

    task automatic idle_input(input int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic write_image_count(input logic [CFG_W-1:0] value);
        in_valid <= 1'b0;
        while (median_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        image_count_cfg = value;
        cfg_writes++;
    endtask

    // Result side: stall pattern and comparison against the oldest expected median
    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {median_blue, median_green, median_red};
            if (median_q.size() == 0)
                log_failure($sformatf("unexpected median %0d/%0d/%0d",
                                      got[0], got[1], got[2]));
            else
            begin
                want = median_q.pop_front();
                medians_checked++;
                if (got[0] !== want[0] || got[1] !== want[1] || got[2] !== want[2])
                    log_failure($sformatf(
                        "median mismatch r/g/b: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                        want[0], want[1], want[2], got[0], got[1], got[2]));
            end
        end

        if (mode_timer == 0)
        begin
            stall_mode <= stall_mode_e'($urandom_range(0, 3));
            mode_timer <= $urandom_range(20, 80);
        end
        else
            mode_timer <= mode_timer - 1;
        stall_phase <= stall_phase + 1'b1;
        case (stall_mode)
            STALL_SPARSE:   out_stall <= ($urandom_range(0, 2) == 0);
            STALL_PERIODIC: out_stall <= (stall_phase < 4'd6);
            STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
            default:        out_stall <= 1'b0;
        endcase
    end

    initial
    begin : stimulus
        stim_row_t        directed_rows [$];
        logic [CFG_W-1:0] edge_counts [5];
        logic [CFG_W-1:0] count;
        data_mode_e       data_mode;
        pixel_t           w;
        int               random_words;
        int               phase;
        int               phase_words;
        int               burst;
        int               pick;
        int               directed_words;

        edge_counts = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd17};
        directed_rows = '{
            // reset count of nine
            '{ROW_WORD,   5'd0, px(200,  17,   3), 1'b0, '0},
            '{ROW_WORD,   5'd0, px(  0, 255, 128), 1'b0, '0},
            '{ROW_WORD,   5'd0, px(255,   0,  64), 1'b0, '0},
            '{ROW_WORD,   5'd0, px( 10,   1, 255), 1'b0, '0},
            '{ROW_WORD,   5'd0, px( 50,  99,   0), 1'b0, '0},
            '{ROW_WORD,   5'd0, px(128, 128, 128), 1'b0, '0},
            '{ROW_WORD,   5'd0, px(  7, 250,  77), 1'b0, '0},
            '{ROW_WORD,   5'd0, px( 99,  33, 190), 1'b0, '0},
            '{ROW_WORD,   5'd0, px(  1,   5,  12), 1'b0, '0},
            // one image: every word is its own median
            '{ROW_CONFIG, 5'd1, '0, 1'b0, '0},
            '{ROW_WORD,   5'd0, px(255, 255, 255), 1'b1, px(255, 255, 255)},
            '{ROW_WORD,   5'd0, px(  0,   0,   0), 1'b1, px(  0,   0,   0)},
            '{ROW_WORD,   5'd0, px(170,  85,  15), 1'b1, px(170,  85,  15)},
            // zero acts as one
            '{ROW_CONFIG, 5'd0, '0, 1'b0, '0},
            '{ROW_WORD,   5'd0, px( 85, 170, 240), 1'b1, px( 85, 170, 240)},
            // two images: upper of the two
            '{ROW_CONFIG, 5'd2, '0, 1'b0, '0},
            '{ROW_WORD,   5'd0, px( 10,  20,  30), 1'b0, '0},
            '{ROW_WORD,   5'd0, px(200, 100,   0), 1'b1, px(200, 100,  30)},
            // count lowered below the samples already gathered
            '{ROW_CONFIG, 5'd4, '0, 1'b0, '0},
            '{ROW_WORD,   5'd0, px( 40,  40,  40), 1'b0, '0},
            '{ROW_WORD,   5'd0, px( 10, 250,   5), 1'b0, '0},
            '{ROW_WORD,   5'd0, px( 90,  60, 200), 1'b0, '0},
            '{ROW_CONFIG, 5'd2, '0, 1'b0, '0},
            '{ROW_WORD,   5'd0, px( 70,  70,  70), 1'b0, '0},
            // ties
            '{ROW_CONFIG, 5'd3, '0, 1'b0, '0},
            '{ROW_WORD,   5'd0, px(255,   0, 255), 1'b0, '0},
            '{ROW_WORD,   5'd0, px(255,   0,   0), 1'b0, '0},
            '{ROW_WORD,   5'd0, px(  0, 255, 255), 1'b0, '0}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CONFIG)
                write_image_count(directed_rows[i].count);
            else
            begin
                send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
                idle_input($urandom_range(0, 2));
            end
        end
        directed_words = words_sent;

        random_words = 0;
        phase = 0;
        while (random_words < RANDOM_WORDS)
        begin
            if (phase < 5)
                count = edge_counts[phase];
            else if ($urandom_range(0, 7) == 0)
                count = ($urandom_range(0, 3) == 0) ? 5'd0 : CFG_W'($urandom_range(17, 31));
            else
                count = CFG_W'($urandom_range(1, MAX_IMAGES));
            write_image_count(count);
            phase_words = $urandom_range(30, 120);
            while (phase_words > 0 && random_words < RANDOM_WORDS)
            begin
                burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 8);
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    data_mode = DATA_FULL;
                else if (pick == 6)
                    data_mode = DATA_NARROW;
                else if (pick == 7)
                    data_mode = DATA_EXTREME;
                else
                    data_mode = DATA_EDGE;
                while (burst > 0 && phase_words > 0)
                begin
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        case (data_mode)
                            DATA_NARROW:  w[c] = FIELD_W'($urandom_range(0, 3));
                            DATA_EXTREME: w[c] = $urandom_range(0, 1) ? '1 : '0;
                            DATA_EDGE:    w[c] = $urandom_range(0, 1)
                                                 ? FIELD_W'($urandom_range(248, 255))
                                                 : FIELD_W'($urandom_range(0, 7));
                            default:      w[c] = FIELD_W'($urandom_range(0, 255));
                        endcase
                    end
                    send_word(w, 1'b0, '0);
                    burst--;
                    phase_words--;
                    random_words++;
                end
                idle_input(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
            end
            phase++;
        end

        in_valid <= 1'b0;
        while (median_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Stacked %0d words (%0d directed) over %0d image-count settings;",
                 words_sent, directed_words, cfg_writes);
        $display("checked %0d medians, %0d mismatches.", medians_checked, mismatches);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("Timeout: %0d medians still expected", median_q.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/pms_pkg.sv
hw/rtl/pms_cell.sv
hw/rtl/pms_median_out.sv
hw/rtl/per_pixel_median_stack_core.sv
bench/per_pixel_median_stack_core_tb.sv
